@@ hdl/pdf_pkg.sv @@
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the packet duplicate filter.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int ID_W     = 32;
    localparam int LEN_W    = 11;
    localparam int KIND_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 2;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [ID_W-1:0]     t_id;
    typedef logic [BYTE_W-1:0]   t_byte;

    localparam t_action ACT_IGNORE  = 2'd0;
    localparam t_action ACT_DUP     = 2'd1;
    localparam t_action ACT_NEW     = 2'd2;
    localparam t_action ACT_RELEASE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK    = 4'd0;
    localparam logic [LEN_W-1:0]  MIN_PAYLOAD = 11'd3;

endpackage

@@ hdl/packet_duplicate_filter.sv @@
// ----------------------------------------------------------------------------
// packet_duplicate_filter
// Classifies received datagram headers and keeps a window of accepted ids.
// ----------------------------------------------------------------------------
// Usage:
//   An item (header fields) is taken at a clock edge where start is high and
//   busy is low. Each item gives exactly one result, shown for one cycle with
//   o_strobe high; the receiver cannot stall, so nothing is held back.
//   Ignored items, releases, ids at or below the floor and the first id into
//   an empty window give their result in the cycle after acceptance, and busy
//   stays low, so such items may follow back to back.
//   Any other data item scans the stored ids, held in a memory with one write
//   port and one registered read port, one read a cycle over all N stored ids
//   (N at most WINDOW_SIZE). busy is high meanwhile; the write back of a new
//   id happens in the final state, S_FIN.
//   Stored entries always fill slots 0 to N-1, so a fill count replaces
//   per-entry valid bits and no clearing pass is needed.
//   The own address register is written through i_cfg_valid/o_cfg_ready,
//   always ready; write it only while idle.
//   Reset empties the window, zeroes the floor and the own address.
// ----------------------------------------------------------------------------
module packet_duplicate_filter #(
    parameter int WINDOW_SIZE = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_is_unicast,
    input  logic [pdf_pkg::LEN_W-1:0]  i_payload_length,
    input  logic [pdf_pkg::KIND_W-1:0] i_packet_kind,
    input  pdf_pkg::t_byte             i_packet_type,
    input  pdf_pkg::t_id               i_packet_id,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  pdf_pkg::t_byte             i_cfg_data,
    output logic                       o_strobe,
    output pdf_pkg::t_action           o_action,
    output pdf_pkg::t_id               o_echo_id,
    output pdf_pkg::t_byte             o_reply_type,
    output pdf_pkg::t_byte             o_reply_source
);
    import pdf_pkg::*;

    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);
    localparam logic [CW-1:0] W_CNT = CW'(WINDOW_SIZE);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    t_id           r_mem [WINDOW_SIZE];
    t_id           r_rd_data;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    t_id           r_id_floor;
    t_byte         r_own;
    t_id           r_id;
    t_byte         r_type;
    logic [CW-1:0] r_issue;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic          r_match;
    t_id           r_min;
    logic [AW-1:0] r_min_slot;

    logic          r_strobe;
    t_action       r_action;
    t_id           r_echo;
    t_byte         r_rtype;
    t_byte         r_rsrc;

    logic          w_accept;
    logic          w_ignore;
    logic          w_release;
    logic          w_dup_fast;
    logic          w_last;
    logic          w_we;
    logic [AW-1:0] w_wa;
    t_id           w_wd;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_ignore    = !i_is_unicast || (i_payload_length <= MIN_PAYLOAD);
    assign w_release   = (i_packet_kind == KIND_ACK);
    assign w_dup_fast  = (i_packet_id <= r_id_floor);
    assign w_last      = r_pend && ((CW'(r_pend_idx) + CW'(1)) == r_count);

    // single write port: first fill, append or replace of the minimum
    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = r_id;
        if (r_state == S_IDLE) begin
            if (w_accept && !w_ignore && !w_release && !w_dup_fast
                    && (r_count == '0)) begin
                w_we = 1'b1;
                w_wd = i_packet_id;
            end
        end else if (r_state == S_FIN && !r_match) begin
            if (r_count != W_CNT) begin
                w_we = 1'b1;
                w_wa = r_count[AW-1:0];
            end else if (!(r_id < r_min)) begin
                w_we = 1'b1;
                w_wa = r_min_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[r_issue[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_id_floor <= '0;
            r_own      <= '0;
            r_strobe   <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid) begin
                r_own <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_id    <= i_packet_id;
                        r_type  <= i_packet_type;
                        r_match <= 1'b0;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_echo  <= i_packet_id;
                        r_rtype <= i_packet_type;
                        r_rsrc  <= r_own;
                        if (w_ignore) begin
                            r_strobe <= 1'b1;
                            r_action <= ACT_IGNORE;
                            r_echo   <= '0;
                            r_rtype  <= '0;
                            r_rsrc   <= '0;
                        end else if (w_release) begin
                            r_strobe <= 1'b1;
                            r_action <= ACT_RELEASE;
                            r_rtype  <= '0;
                            r_rsrc   <= '0;
                        end else if (w_dup_fast) begin
                            r_strobe <= 1'b1;
                            r_action <= ACT_DUP;
                        end else if (r_count == '0) begin
                            r_strobe <= 1'b1;
                            r_action <= ACT_NEW;
                            r_count  <= CW'(1);
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue < r_count) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_issue[AW-1:0];
                        r_issue    <= r_issue + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (r_rd_data == r_id) begin
                            r_match <= 1'b1;
                        end
                        if ((r_pend_idx == '0) || (r_rd_data < r_min)) begin
                            r_min      <= r_rd_data;
                            r_min_slot <= r_pend_idx;
                        end
                    end
                    if (w_last) begin
                        r_state <= S_FIN;
                        r_pend  <= 1'b0;
                    end
                end
                S_FIN: begin
                    r_strobe <= 1'b1;
                    r_echo   <= r_id;
                    r_rtype  <= r_type;
                    r_rsrc   <= r_own;
                    r_state  <= S_IDLE;
                    if (r_match) begin
                        r_action <= ACT_DUP;
                    end else begin
                        r_action <= ACT_NEW;
                        if (r_count != W_CNT) begin
                            r_count <= r_count + CW'(1);
                        end else if (r_id < r_min) begin
                            r_id_floor <= r_id;
                        end else begin
                            r_id_floor <= r_min;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_action       = r_action;
    assign o_echo_id      = r_echo;
    assign o_reply_type   = r_rtype;
    assign o_reply_source = r_rsrc;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= W_CNT)
        else $error("fill count beyond window size");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_strobe || busy))
        else $error("accepted item neither answered nor in progress");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_strobe && (o_action == ACT_DUP || o_action == ACT_NEW)))
        else $error("scan finished without a data result");

    a_floor_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_id_floor >= $past(r_id_floor)))
        else $error("id floor went down");

    a_ignore_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_action == ACT_IGNORE) |->
            (o_echo_id == '0 && o_reply_type == '0 && o_reply_source == '0))
        else $error("ignored item with non-zero fields");

endmodule
